// ----- rtl/cph_pkg.sv -----
`timescale 1ns / 1ps

package cph_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int PAGE_SIZE   = 128;
    localparam int PAGES       = 512;

    localparam int SYMBOLS    = 65536;
    localparam int ROW_LEN    = PAGES + 1;
    localparam int TR_DEPTH   = PAGES * ROW_LEN;

    localparam int CP_W       = 16;
    localparam int COL_W      = 10;
    localparam int OUT_PAGE_W = 9;
    localparam int OUT_CNT_W  = 32;
    localparam int SYM_AW     = $clog2(SYMBOLS);
    localparam int PG_AW      = $clog2(PAGES);
    localparam int TR_AW      = $clog2(TR_DEPTH);
    localparam int PAGE_SHIFT = $clog2(PAGE_SIZE);

    localparam logic [COL_W-1:0]       SPECIAL_COL = COL_W'(PAGES);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = '1;
    localparam logic [TR_AW-1:0]       CLR_LAST    = TR_AW'(TR_DEPTH - 1);

    localparam int IN_DW    = 32;
    localparam int OUT_USED = 3 * OUT_CNT_W + OUT_PAGE_W + COL_W;
    localparam int OUT_DW   = ((OUT_USED + 7) / 8) * 8;

    localparam logic [1:0] OP_COUNT   = 2'd0;
    localparam logic [1:0] OP_NEWLINE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [SYM_AW-1:0] sym_addr;
        logic [PG_AW-1:0]  page;
        logic [COL_W-1:0]  col;
        logic [TR_AW-1:0]  tr_addr;
    } t_stage;

endpackage

// ----- rtl/cph_ram.sv -----
`timescale 1ns / 1ps

module cph_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/code_page_histogram.sv -----
`timescale 1ns / 1ps
// Code point histogram with page and page-transition counts.
// Input stream (s): one beat per code point, new-line mark or read request;
// tuser carries the op, tdata the code point and, for reads, the transition
// column. Output stream (m): exactly one beat per input beat, in order, with
// the symbol, page and transition counts, the page and the column used.
// Throughput is one beat per cycle while the output is not stalled: each
// count store is a RAM with a registered read; the stage after the read adds
// one, saturates and writes back, and a bypass register per store covers
// back-to-back hits on the same entry. An accepted beat is registered in the
// read stage, then in the output register. After reset the three stores are
// cleared one address per cycle over all 262656 transition addresses, with
// s_tready low. The page history (previous and older page) resets to zero at once.
// When the receiver holds m_tready low, the output register holds its beat,
// the read stage holds, and s_tready drops until the output drains.
module code_page_histogram
    import cph_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // [15:0] code_point, [25:16] read_column, [31:26] zero
    input  logic [IN_DW-1:0]  i_s_tdata,
    // [1:0] op
    input  logic [1:0]        i_s_tuser,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // [31:0] symbol_count, [63:32] page_count, [95:64] transition_count,
    // [104:96] page, [114:105] column_used, [119:115] zero
    output logic [OUT_DW-1:0] o_m_tdata
);

    logic                   r_clearing;
    logic [TR_AW-1:0]       r_clr_addr;
    logic [PG_AW-1:0]       r_prev;
    logic [PG_AW-1:0]       r_older;
    logic                   r_s1_valid;
    t_stage                 r_s1;
    logic                   r_out_valid;
    logic [OUT_DW-1:0]      r_out_data;

    logic                   r_fw_sym_valid;
    logic [SYM_AW-1:0]      r_fw_sym_addr;
    logic [COUNT_WIDTH-1:0] r_fw_sym_data;
    logic                   r_fw_pg_valid;
    logic [PG_AW-1:0]       r_fw_pg_addr;
    logic [COUNT_WIDTH-1:0] r_fw_pg_data;
    logic                   r_fw_tr_valid;
    logic [TR_AW-1:0]       r_fw_tr_addr;
    logic [COUNT_WIDTH-1:0] r_fw_tr_data;

    logic                   w_advance;
    logic                   w_accept;
    logic [1:0]             w_op;
    logic [CP_W-1:0]        w_cp;
    logic [COL_W-1:0]       w_rc;
    logic [PG_AW-1:0]       w_page;
    logic [PG_AW-1:0]       w_row;
    t_stage                 w_s0;

    logic [COUNT_WIDTH-1:0] w_sym_rd, w_pg_rd, w_tr_rd;
    logic [COUNT_WIDTH-1:0] w_sym_cur, w_pg_cur, w_tr_cur;
    logic [COUNT_WIDTH-1:0] w_sym_inc, w_pg_inc, w_tr_inc;
    logic                   w_we_count;
    logic                   w_we;
    logic [SYM_AW-1:0]      w_sym_waddr;
    logic [PG_AW-1:0]       w_pg_waddr;
    logic [TR_AW-1:0]       w_tr_waddr;
    logic [COUNT_WIDTH-1:0] w_sym_wdata, w_pg_wdata, w_tr_wdata;
    logic [OUT_DW-1:0]      n_out_data;

    assign w_advance  = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_clearing && w_advance;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_op   = i_s_tuser;
    assign w_cp   = i_s_tdata[CP_W-1:0];
    assign w_rc   = i_s_tdata[CP_W+COL_W-1:CP_W];
    assign w_page = PG_AW'(w_cp >> PAGE_SHIFT);

    always_comb begin
        w_s0          = '0;
        w_s0.op       = w_op;
        w_s0.sym_addr = SYM_AW'(w_cp);
        w_s0.page     = w_page;
        if (w_op == OP_COUNT) begin
            w_row = r_prev;
            if (w_page != r_prev && w_page == r_older) begin
                w_s0.col = SPECIAL_COL;
            end else begin
                w_s0.col = COL_W'(w_page);
            end
        end else begin
            w_row = w_page;
            w_s0.col = (w_rc > SPECIAL_COL) ? SPECIAL_COL : w_rc;
        end
        w_s0.tr_addr = TR_AW'(w_row) * TR_AW'(ROW_LEN) + TR_AW'(w_s0.col);
    end

    always_comb begin
        w_sym_cur = (r_fw_sym_valid && r_fw_sym_addr == r_s1.sym_addr) ?
                    r_fw_sym_data : w_sym_rd;
        w_pg_cur  = (r_fw_pg_valid && r_fw_pg_addr == r_s1.page) ?
                    r_fw_pg_data : w_pg_rd;
        w_tr_cur  = (r_fw_tr_valid && r_fw_tr_addr == r_s1.tr_addr) ?
                    r_fw_tr_data : w_tr_rd;
        w_sym_inc = (w_sym_cur == COUNT_MAX) ? w_sym_cur : w_sym_cur + 1'b1;
        w_pg_inc  = (w_pg_cur == COUNT_MAX) ? w_pg_cur : w_pg_cur + 1'b1;
        w_tr_inc  = (w_tr_cur == COUNT_MAX) ? w_tr_cur : w_tr_cur + 1'b1;
    end

    always_comb begin
        case (r_s1.op)
            OP_COUNT: begin
                n_out_data = {(OUT_DW - OUT_USED)'(0), r_s1.col,
                              OUT_PAGE_W'(r_s1.page), OUT_CNT_W'(w_tr_inc),
                              OUT_CNT_W'(w_pg_inc), OUT_CNT_W'(w_sym_inc)};
            end
            OP_READ: begin
                n_out_data = {(OUT_DW - OUT_USED)'(0), r_s1.col,
                              OUT_PAGE_W'(r_s1.page), OUT_CNT_W'(w_tr_cur),
                              OUT_CNT_W'(w_pg_cur), OUT_CNT_W'(w_sym_cur)};
            end
            default: begin
                n_out_data = '0;
            end
        endcase
    end

    assign w_we_count  = r_s1_valid && w_advance && r_s1.op == OP_COUNT;
    assign w_we        = r_clearing || w_we_count;
    assign w_sym_waddr = r_clearing ? SYM_AW'(r_clr_addr) : r_s1.sym_addr;
    assign w_pg_waddr  = r_clearing ? PG_AW'(r_clr_addr) : r_s1.page;
    assign w_tr_waddr  = r_clearing ? r_clr_addr : r_s1.tr_addr;
    assign w_sym_wdata = r_clearing ? '0 : w_sym_inc;
    assign w_pg_wdata  = r_clearing ? '0 : w_pg_inc;
    assign w_tr_wdata  = r_clearing ? '0 : w_tr_inc;

    cph_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(SYMBOLS)) u_sym_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_sym_waddr),
        .i_wdata (w_sym_wdata),
        .i_re    (w_accept),
        .i_raddr (w_s0.sym_addr),
        .o_rdata (w_sym_rd)
    );

    cph_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(PAGES)) u_pg_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_pg_waddr),
        .i_wdata (w_pg_wdata),
        .i_re    (w_accept),
        .i_raddr (w_s0.page),
        .o_rdata (w_pg_rd)
    );

    cph_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(TR_DEPTH)) u_tr_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_tr_waddr),
        .i_wdata (w_tr_wdata),
        .i_re    (w_accept),
        .i_raddr (w_s0.tr_addr),
        .o_rdata (w_tr_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing     <= 1'b1;
            r_clr_addr     <= '0;
            r_prev         <= '0;
            r_older        <= '0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_fw_sym_valid <= 1'b0;
            r_fw_pg_valid  <= 1'b0;
            r_fw_tr_valid  <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == CLR_LAST) begin
                    r_clearing <= 1'b0;
                end
            end
            if (w_accept) begin
                case (w_op)
                    OP_COUNT: begin
                        r_older <= r_prev;
                        r_prev  <= w_page;
                    end
                    OP_NEWLINE: begin
                        r_prev <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (w_advance) begin
                r_s1_valid  <= w_accept;
                r_out_valid <= r_s1_valid;
            end
            if (w_we_count) begin
                r_fw_sym_valid <= 1'b1;
                r_fw_pg_valid  <= 1'b1;
                r_fw_tr_valid  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= w_s0;
        end
        if (w_advance && r_s1_valid) begin
            r_out_data <= n_out_data;
        end
        if (w_we_count) begin
            r_fw_sym_addr <= r_s1.sym_addr;
            r_fw_sym_data <= w_sym_inc;
            r_fw_pg_addr  <= r_s1.page;
            r_fw_pg_data  <= w_pg_inc;
            r_fw_tr_addr  <= r_s1.tr_addr;
            r_fw_tr_data  <= w_tr_inc;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_s_tready)
        else $error("input beat accepted during clearing pass");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_s1_valid)
        else $error("accepted beat lost before the read stage");

    a_stage_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_advance) |=> o_m_tvalid)
        else $error("read stage advanced without an output beat");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_advance) |=> (r_s1_valid && $stable(r_s1)))
        else $error("read stage changed while the output was stalled");

    a_count_write_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we_count |-> !r_clearing)
        else $error("count write-back during clearing pass");

endmodule
